// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the RTL of the rectangle fill core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication property on the rising clock edge, off while in reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds on the rising clock edge, off while in reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/pbrf_pkg.sv =====
// Package of the rectangle fill core: field widths, mode and status codes and the controller state type.
`timescale 1ns / 1ps

package pbrf_pkg;

  localparam int unsigned MODE_W  = 2;
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned WORD_W  = 16;
  // Wide enough for column + width and for the largest screen size.
  localparam int unsigned CHK_W   = 11;

  localparam logic [MODE_W-1:0] MODE_SET_PIXEL   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FILL_RECT   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FILL_SCREEN = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ_WORD   = 2'd3;

  localparam logic [0:0] STATUS_DONE     = 1'b0;
  localparam logic [0:0] STATUS_REJECTED = 1'b1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_BRD  = 6'b000010,
    S_BWR  = 6'b000100,
    S_FILL = 6'b001000,
    S_SCRN = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

endpackage

// ===== rtl/core/pbrf_in_if.sv =====
// Input channel interface: valid/ready handshake and one command item.
`timescale 1ns / 1ps

interface pbrf_in_if;
  logic                           valid;
  logic                           ready;
  logic [pbrf_pkg::MODE_W-1:0]    mode;
  logic [pbrf_pkg::PIX_W-1:0]     column;
  logic [pbrf_pkg::PIX_W-1:0]     line;
  logic [pbrf_pkg::PIX_W-1:0]     span_width;
  logic [pbrf_pkg::PIX_W-1:0]     span_height;
  logic [pbrf_pkg::PIX_W-1:0]     palette_index;

  modport source (output valid, mode, column, line, span_width, span_height,
                  palette_index, input ready);
  modport sink   (input valid, mode, column, line, span_width, span_height,
                  palette_index, output ready);
endinterface

// ===== rtl/core/pbrf_out_if.sv =====
// Result channel interface: valid/ready handshake and one result item.
`timescale 1ns / 1ps

interface pbrf_out_if;
  logic                           valid;
  logic                           ready;
  logic [pbrf_pkg::WORD_W-1:0]    read_word;
  logic                           status;

  modport source (output valid, read_word, status, input ready);
  modport sink   (input valid, read_word, status, output ready);
endinterface

// ===== rtl/core/packed_byte_pixel_rect_fill_core.sv =====
// Top level: packed 8-bit framebuffer with pixel set, rectangle fill, screen fill, word read.
//
//   channel   dir   handshake      payload
//   in_ch     in    valid/ready    mode, column, line, span_width, span_height, palette_index
//   out_ch    out   valid/ready    read_word, status
//
// Steps: set pixel and read word pass through address, memory read, merge or capture, and
//   result; a rejected item or an empty rectangle goes straight to the result. Fill screen
//   writes one word per cycle. Fill rectangle writes one whole word per cycle and takes
//   each edge byte through a fill step, a memory read and a merge, with a row step at the
//   end of each row, and accept and hand-over around them; the frame memory has a single
//   write port.
// Reset clears the controller state and the output valid; the frame memory keeps no reset.
// Stalls: one item is worked on at a time; a new transfer is taken whenever the
//   controller is idle, even while the previous result waits in the output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module packed_byte_pixel_rect_fill_core #(
  parameter int unsigned SCREEN_COLUMNS = 240,
  parameter int unsigned SCREEN_ROWS    = 160
) (
  input  logic              clk,
  input  logic              rst_n,
  pbrf_in_if.sink           in_ch,
  pbrf_out_if.source        out_ch
);

  // Frame geometry: words per row and memory depth.
  localparam int unsigned PITCH = (SCREEN_COLUMNS + 1) / 2;
  localparam int unsigned WORDS = PITCH * SCREEN_ROWS;
  localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  // One more bit so that row bases and the pitch itself always fit.
  localparam int unsigned AX    = AW + 1;

  localparam int unsigned CW = pbrf_pkg::CHK_W;
  localparam int unsigned PW = pbrf_pkg::PIX_W;
  localparam int unsigned DW = pbrf_pkg::WORD_W;

  // Frame memory, one write port and one registered read port.
  logic [DW-1:0] frame_mem [WORDS];
  logic [DW-1:0] rd_data_r;

  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [DW-1:0] mem_wd;

  // Controller registers.
  pbrf_pkg::state_t state_r, state_nxt;
  logic [pbrf_pkg::MODE_W-1:0] mode_r, mode_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic          odd_r, odd_nxt;
  logic [PW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] c_r, c_nxt;
  logic [CW-1:0] start_r, start_nxt;
  logic [CW-1:0] end_r, end_nxt;
  logic [PW-1:0] rows_left_r, rows_left_nxt;
  logic [AX-1:0] base_r, base_nxt;

  // Pending result, then the output register.
  logic [DW-1:0] res_word_r, res_word_nxt;
  logic          res_status_r, res_status_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [DW-1:0] out_word_r, out_word_nxt;
  logic          out_status_r, out_status_nxt;

  // Decode of the incoming item.
  logic          in_take;
  logic [CW-1:0] in_col_x, in_line_x, in_right_x, in_bottom_x;
  logic          pix_off, rect_off, rect_empty;
  logic [AX-1:0] in_base;
  logic [AX-1:0] in_pix_addr;
  logic [AX-1:0] cur_addr;
  logic [DW-1:0] pair;

  assign in_ch.ready = (state_r == pbrf_pkg::S_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;

  assign in_col_x    = CW'(in_ch.column);
  assign in_line_x   = CW'(in_ch.line);
  assign in_right_x  = in_col_x + CW'(in_ch.span_width);
  assign in_bottom_x = in_line_x + CW'(in_ch.span_height);

  assign pix_off    = (in_col_x >= CW'(SCREEN_COLUMNS)) || (in_line_x >= CW'(SCREEN_ROWS));
  assign rect_off   = (in_right_x > CW'(SCREEN_COLUMNS)) || (in_bottom_x > CW'(SCREEN_ROWS));
  assign rect_empty = (in_ch.span_width == '0) || (in_ch.span_height == '0);

  // Row base times a constant pitch; only used when the row is on screen.
  assign in_base     = AX'(AX'(in_ch.line) * AX'(PITCH));
  assign in_pix_addr = in_base + AX'(in_ch.column >> 1);

  // Word address of the fill cursor.
  assign cur_addr = base_r + AX'(c_r >> 1);
  assign pair     = {idx_r, idx_r};

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    addr_nxt       = addr_r;
    odd_nxt        = odd_r;
    idx_nxt        = idx_r;
    c_nxt          = c_r;
    start_nxt      = start_r;
    end_nxt        = end_r;
    rows_left_nxt  = rows_left_r;
    base_nxt       = base_r;
    res_word_nxt   = res_word_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_word_nxt   = out_word_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_wa         = addr_r;
    mem_wd         = pair;

    case (state_r)
      pbrf_pkg::S_IDLE: begin
        if (in_take) begin
          mode_nxt       = in_ch.mode;
          idx_nxt        = in_ch.palette_index;
          odd_nxt        = in_ch.column[0];
          res_word_nxt   = '0;
          res_status_nxt = pbrf_pkg::STATUS_DONE;
          case (in_ch.mode)
            pbrf_pkg::MODE_SET_PIXEL, pbrf_pkg::MODE_READ_WORD: begin
              if (pix_off) begin
                res_status_nxt = pbrf_pkg::STATUS_REJECTED;
                state_nxt      = pbrf_pkg::S_DONE;
              end else begin
                addr_nxt  = AW'(in_pix_addr);
                state_nxt = pbrf_pkg::S_BRD;
              end
            end
            pbrf_pkg::MODE_FILL_RECT: begin
              if (rect_off) begin
                res_status_nxt = pbrf_pkg::STATUS_REJECTED;
                state_nxt      = pbrf_pkg::S_DONE;
              end else if (rect_empty) begin
                state_nxt = pbrf_pkg::S_DONE;
              end else begin
                c_nxt         = in_col_x;
                start_nxt     = in_col_x;
                end_nxt       = in_right_x;
                rows_left_nxt = in_ch.span_height;
                base_nxt      = in_base;
                state_nxt     = pbrf_pkg::S_FILL;
              end
            end
            default: begin
              addr_nxt  = '0;
              state_nxt = pbrf_pkg::S_SCRN;
            end
          endcase
        end
      end

      // Memory read of addr_r is in flight.
      pbrf_pkg::S_BRD: begin
        state_nxt = pbrf_pkg::S_BWR;
      end

      // Merge the byte into the word read back, or capture it for read mode.
      pbrf_pkg::S_BWR: begin
        if (mode_r == pbrf_pkg::MODE_READ_WORD) begin
          res_word_nxt = rd_data_r;
          state_nxt    = pbrf_pkg::S_DONE;
        end else begin
          mem_we = 1'b1;
          mem_wd = odd_r ? {idx_r, rd_data_r[7:0]} : {rd_data_r[15:8], idx_r};
          state_nxt = (mode_r == pbrf_pkg::MODE_FILL_RECT) ? pbrf_pkg::S_FILL
                                                           : pbrf_pkg::S_DONE;
        end
      end

      pbrf_pkg::S_FILL: begin
        if (c_r >= end_r) begin
          // End of row: step down or finish.
          if (rows_left_r == PW'(1)) begin
            state_nxt = pbrf_pkg::S_DONE;
          end else begin
            rows_left_nxt = rows_left_r - PW'(1);
            base_nxt      = base_r + AX'(PITCH);
            c_nxt         = start_r;
          end
        end else if (c_r[0] || (c_r + CW'(1) == end_r)) begin
          // Edge byte: read-modify-write.
          addr_nxt  = AW'(cur_addr);
          odd_nxt   = c_r[0];
          c_nxt     = c_r + CW'(1);
          state_nxt = pbrf_pkg::S_BRD;
        end else begin
          mem_we = 1'b1;
          mem_wa = AW'(cur_addr);
          c_nxt  = c_r + CW'(2);
        end
      end

      pbrf_pkg::S_SCRN: begin
        mem_we = 1'b1;
        if (addr_r == AW'(WORDS - 1)) begin
          state_nxt = pbrf_pkg::S_DONE;
        end else begin
          addr_nxt = addr_r + AW'(1);
        end
      end

      pbrf_pkg::S_DONE: begin
        // Hand over once the output register is free or being drained.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_word_nxt   = res_word_r;
          out_status_nxt = res_status_r;
          state_nxt      = pbrf_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = pbrf_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pbrf_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    addr_r       <= addr_nxt;
    odd_r        <= odd_nxt;
    idx_r        <= idx_nxt;
    c_r          <= c_nxt;
    start_r      <= start_nxt;
    end_r        <= end_nxt;
    rows_left_r  <= rows_left_nxt;
    base_r       <= base_nxt;
    res_word_r   <= res_word_nxt;
    res_status_r <= res_status_nxt;
    out_word_r   <= out_word_nxt;
    out_status_r <= out_status_nxt;
  end

  // Frame memory ports.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= frame_mem[addr_r];
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_word = out_word_r;
  assign out_ch.status    = out_status_r;

  `ASSERT_NEVER(a_no_write_idle, (state_r == pbrf_pkg::S_IDLE) && mem_we,
                "frame memory written while idle")
  `ASSERT_CLK(a_read_then_merge, (state_r == pbrf_pkg::S_BRD) |=> (state_r == pbrf_pkg::S_BWR),
              "memory read not followed by merge")
  `ASSERT_CLK(a_cursor_bound, (state_r == pbrf_pkg::S_FILL) |-> (c_r <= end_r),
              "fill cursor past right edge")
  `ASSERT_CLK(a_screen_start,
              (in_take && (in_ch.mode == pbrf_pkg::MODE_FILL_SCREEN))
                |=> ((state_r == pbrf_pkg::S_SCRN) && (addr_r == '0)),
              "screen fill did not start at word zero")

endmodule
